>>> hw/rtl/sprgs_pkg.sv
// ----------------------------------------------------------------------------
// sprgs_pkg
// Shared constants and controller/datapath types for the set partition
// restricted growth string generator.
// ----------------------------------------------------------------------------
package sprgs_pkg;

  localparam int unsigned MaxLenDefault = 8;
  localparam int unsigned LenW          = 4;
  localparam int unsigned DigitW        = 3;
  localparam int unsigned ShownDigits   = 8;
  localparam int unsigned DigitsW       = DigitW * ShownDigits;

  localparam logic [LenW-1:0]   SetLengthReset = 4'd4;
  localparam logic [DigitW-1:0] DigitMax       = 3'd7;

  typedef struct packed {
    logic restart;
    logic exhaust;
    logic scan_start;
    logic scan_step;
    logic update;
    logic load;
  } sprgs_cmd_t;

  typedef struct packed {
    logic no_scan;
    logic scan_last;
  } sprgs_status_t;

endpackage

>>> hw/rtl/sprgs_if.sv
// ----------------------------------------------------------------------------
// sprgs_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface sprgs_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface sprgs_out_if;
  import sprgs_pkg::*;

  logic               valid;
  logic               ready;
  logic [DigitsW-1:0] digits;
  logic               is_last;
  logic               exhausted;

  modport source (output valid, output digits, output is_last, output exhausted, input ready);
  modport sink   (input valid, input digits, input is_last, input exhausted, output ready);
endinterface

>>> hw/rtl/set_partition_rgs_generator_core.sv
// advance: from acceptance, a scan of the digit store at one digit per cycle,
// then an update step and a result load once the output register is free
// restart, or advance after the final string or at length below two: straight to the result load
// a new request is taken while the previous result still waits in the output register
// reset: all digits zero, set_length 4, not finished, no result pending
// ----------------------------------------------------------------------------
// set_partition_rgs_generator_core
// Restricted growth string generator, one string per request transaction.
// ----------------------------------------------------------------------------
module set_partition_rgs_generator_core #(
  parameter int unsigned MAX_LEN = sprgs_pkg::MaxLenDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [sprgs_pkg::LenW-1:0] cfg_wdata_i,
  sprgs_in_if.sink                   in_i,
  sprgs_out_if.source                out_o
);
  import sprgs_pkg::*;

  sprgs_cmd_t         cmd;
  sprgs_status_t      status;
  logic               in_ready;
  logic               out_valid;
  logic [DigitsW-1:0] digits;
  logic               is_last;
  logic               exhausted;

  sprgs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_restart_i (in_i.restart),
    .in_ready_o   (in_ready),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_valid),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  sprgs_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .digits_o    (digits),
    .is_last_o   (is_last),
    .exhausted_o (exhausted)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.digits    = digits;
  assign out_o.is_last   = is_last;
  assign out_o.exhausted = exhausted;

endmodule

>>> hw/rtl/sprgs_ctrl.sv
// ----------------------------------------------------------------------------
// sprgs_ctrl
// Sequencer: accepts a request, steps the digit scan and loads the result
// register when it is free.
// ----------------------------------------------------------------------------
module sprgs_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_restart_i,
  output logic                     in_ready_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  input  sprgs_pkg::sprgs_status_t status_i,
  output sprgs_pkg::sprgs_cmd_t    cmd_o
);
  import sprgs_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StLoad
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    in_ready_o  = (state_q == StIdle);
    accept      = in_valid_i && in_ready_o;
    out_free    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_restart_i) begin
            cmd_o.restart = 1'b1;
            state_d       = StLoad;
          end else if (status_i.no_scan) begin
            cmd_o.exhaust = 1'b1;
            state_d       = StLoad;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StLoad;
      end
      StLoad: begin
        if (out_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/sprgs_dpath.sv
// ----------------------------------------------------------------------------
// sprgs_dpath
// Digit store, length register, left-to-right scan with running maximum,
// string update and result register.
// ----------------------------------------------------------------------------
module sprgs_dpath #(
  parameter int unsigned MAX_LEN = sprgs_pkg::MaxLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sprgs_pkg::LenW-1:0]    cfg_wdata_i,
  input  sprgs_pkg::sprgs_cmd_t         cmd_i,
  output sprgs_pkg::sprgs_status_t      status_o,
  output logic [sprgs_pkg::DigitsW-1:0] digits_o,
  output logic                          is_last_o,
  output logic                          exhausted_o
);
  import sprgs_pkg::*;

  localparam int unsigned IdxW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CntW  = $clog2(MAX_LEN + 1);
  localparam int unsigned ShowN = (MAX_LEN < ShownDigits) ? MAX_LEN : ShownDigits;

  logic [LenW-1:0]    len_q;
  logic [CntW-1:0]    eff_len;
  logic [CntW-1:0]    cap;
  logic [DigitW-1:0]  dig_q [MAX_LEN];
  logic               finished_q;
  logic               exh_q;

  logic [CntW-1:0]    k_q;
  logic [DigitW-1:0]  max_q;
  logic [IdxW-1:0]    pos_q;
  logic [DigitW-1:0]  pos_max_q;
  logic [DigitW-1:0]  pos_dig_q;
  logic               found_q;
  logic               multi_q;

  logic [DigitW-1:0]  cur_dig;
  logic               qualify;
  logic [DigitW-1:0]  inc;
  logic               newq;
  logic               more_right;
  logic [DigitsW-1:0] packed_digits;

  logic [DigitsW-1:0] digits_q;
  logic               is_last_q;
  logic               exhausted_q;

  always_comb begin
    if (int'(len_q) > int'(MAX_LEN)) begin
      eff_len = CntW'(MAX_LEN);
    end else begin
      eff_len = CntW'(len_q);
    end
  end

  assign cap     = eff_len - CntW'(1);
  assign cur_dig = dig_q[k_q[IdxW-1:0]];
  assign qualify = (k_q != '0) && (int'(cur_dig) < int'(cap)) &&
                   (cur_dig <= max_q) && (cur_dig < DigitMax);

  // candidate after increment, for the final-string test
  assign inc        = pos_dig_q + DigitW'(1);
  assign newq       = (int'(inc) < int'(cap)) && (inc <= pos_max_q) && (inc < DigitMax);
  assign more_right = int'(pos_q) < int'(cap);

  assign status_o.no_scan   = finished_q || (int'(eff_len) < 2);
  assign status_o.scan_last = (k_q == cap);

  always_comb begin
    packed_digits = '0;
    for (int i = 0; i < ShowN; i++) begin
      if (i < int'(eff_len)) begin
        packed_digits[i*DigitW +: DigitW] = dig_q[i];
      end
    end
  end

  // digit store, length register and finished flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= SetLengthReset;
      finished_q <= 1'b0;
      for (int i = 0; i < MAX_LEN; i++) begin
        dig_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      len_q      <= cfg_wdata_i;
      finished_q <= 1'b0;
      for (int i = 0; i < MAX_LEN; i++) begin
        dig_q[i] <= '0;
      end
    end else if (cmd_i.restart) begin
      finished_q <= (int'(eff_len) < 2);
      for (int i = 0; i < MAX_LEN; i++) begin
        dig_q[i] <= '0;
      end
    end else if (cmd_i.exhaust) begin
      finished_q <= 1'b1;
    end else if (cmd_i.update) begin
      if (found_q) begin
        for (int i = 0; i < MAX_LEN; i++) begin
          if (i == int'(pos_q)) begin
            dig_q[i] <= inc;
          end else if (i > int'(pos_q)) begin
            dig_q[i] <= '0;
          end
        end
        finished_q <= !(more_right || newq || multi_q);
      end else begin
        finished_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exh_q <= 1'b0;
    end else if (cmd_i.restart) begin
      exh_q <= 1'b0;
    end else if (cmd_i.exhaust) begin
      exh_q <= 1'b1;
    end else if (cmd_i.update) begin
      exh_q <= !found_q;
    end
  end

  // scan: rightmost qualifying position and whether another one lies left of it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      max_q   <= '0;
      found_q <= 1'b0;
      multi_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      k_q     <= '0;
      max_q   <= '0;
      found_q <= 1'b0;
      multi_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      k_q <= k_q + CntW'(1);
      if (cur_dig > max_q) begin
        max_q <= cur_dig;
      end
      if (qualify) begin
        found_q <= 1'b1;
        multi_q <= found_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && qualify) begin
      pos_q     <= k_q[IdxW-1:0];
      pos_max_q <= max_q;
      pos_dig_q <= cur_dig;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      digits_q    <= packed_digits;
      is_last_q   <= finished_q;
      exhausted_q <= exh_q;
    end
  end

  assign digits_o    = digits_q;
  assign is_last_o   = is_last_q;
  assign exhausted_o = exhausted_q;

endmodule

>>> hw/rtl/sprgs_checker.sv
// ----------------------------------------------------------------------------
// sprgs_checker
// Port-level checks on the generator, bound to the top level.
// ----------------------------------------------------------------------------
module sprgs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [sprgs_pkg::DigitsW-1:0] out_digits_i,
  input logic                          out_is_last_i,
  input logic                          out_exhausted_i
);
  import sprgs_pkg::*;

  // result transaction stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while another is in work");

  // an exhausted advance always reports the final string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_exhausted_i |-> out_is_last_i)
    else $error("exhausted result not flagged as last");

  // the leading digit never grows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_digits_i[DigitW-1:0] == '0)
    else $error("leading digit not zero");

endmodule

bind set_partition_rgs_generator_core sprgs_checker u_sprgs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_digits_i    (out_o.digits),
  .out_is_last_i   (out_o.is_last),
  .out_exhausted_i (out_o.exhausted)
);
